>>> hdl/lsta_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the lazy segment tree block.
// No dependencies.
package lsta_pkg;
	localparam int unsigned CapacityDef = 1024;
	localparam int unsigned HeightDef   = 11;
	localparam int unsigned ValW        = 32;

	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_ASSIGN = 2'd1;
	localparam logic [1:0] KIND_SUM    = 2'd2;
endpackage

>>> hdl/lsta_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read.
// No dependencies.
module lsta_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> hdl/lazy_segment_tree_assign_sum.sv
`timescale 1ns / 1ps
// Top level of the lazy range-assign / range-sum segment tree.
// Depends on lsta_pkg and lsta_ram.
//
// Usage: the input channel (in_valid / in_stall) carries one operation per
// beat: kind selects a leaf load, a range assign or a range sum over the
// half-open leaf range [lo, hi). The output channel (out_valid / out_stall)
// carries one beat per assign or sum with the wrapped sum and a status bit;
// loads and unknown kinds produce no output beat.
// The tree lives in two single-port-read RAMs: node sums (2*CAPACITY
// entries) and pending assignments (CAPACITY entries). One operation is
// worked at a time by a sequencer that does at most one read and one write
// per RAM per cycle. A push along one leaf path reads the pending store at
// each level, then writes, with two more writes per node that carries a
// pending value; the range walk visits each level in a left and a right
// step; a rebuild reads two children and writes their parent at each level.
// The number of RAM accesses along the paths sets how long each operation
// runs; a bad range skips the RAMs and goes straight to the result.
// After reset a clearing sweep writes zero to every entry; in_stall stays
// high throughout it. A finished result sits in the output register; the
// next item is accepted while it waits, and only the delivery of the
// following result waits on out_stall.
module lazy_segment_tree_assign_sum
	import lsta_pkg::*;
#(
	parameter int unsigned CAPACITY = CapacityDef,
	parameter int unsigned HEIGHT   = HeightDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   kind,
	input  logic [$clog2(CAPACITY)-1:0]  lo,
	input  logic [$clog2(CAPACITY):0]    hi,
	input  logic signed [ValW-1:0]       value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [ValW-1:0]       sum,
	output logic                         status
);
	localparam int unsigned AW = $clog2(2 * CAPACITY);
	localparam int unsigned PW = $clog2(CAPACITY);
	localparam int unsigned NW = AW + 1;
	localparam int unsigned KW = $clog2(HEIGHT + 1);
	localparam logic [NW-1:0] CapN = NW'(CAPACITY);
	localparam logic [AW-1:0] ClrLast = AW'(2 * CAPACITY - 1);
	localparam logic [PW:0] CapH = (PW + 1)'(CAPACITY);

	localparam logic [3:0] S_CLR     = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_PUSH_RD = 4'd2;
	localparam logic [3:0] S_PUSH_W1 = 4'd3;
	localparam logic [3:0] S_PUSH_W2 = 4'd4;
	localparam logic [3:0] S_PUSH_W3 = 4'd5;
	localparam logic [3:0] S_LOAD_W  = 4'd6;
	localparam logic [3:0] S_LOOP_L  = 4'd7;
	localparam logic [3:0] S_LOOP_R  = 4'd8;
	localparam logic [3:0] S_REB_R1  = 4'd9;
	localparam logic [3:0] S_REB_R2  = 4'd10;
	localparam logic [3:0] S_REB_W   = 4'd11;
	localparam logic [3:0] S_DONE    = 4'd12;

	logic [3:0]      st_q;
	logic [AW-1:0]   clr_q;
	logic [1:0]      kind_q;
	logic [PW-1:0]   lo_q;
	logic [PW:0]     hi_q;
	logic [ValW-1:0] v_q;
	logic            pass_q;
	logic [PW-1:0]   leaf_q;
	logic [KW-1:0]   lvl_q;
	logic [ValW-1:0] d_q;
	logic [NW-1:0]   l_q;
	logic [NW-1:0]   r_q;
	logic [NW-1:0]   pos_q;
	logic [ValW-1:0] total_q;
	logic            acc_q;
	logic            err_q;
	logic [ValW-1:0] pend_q;
	logic [ValW-1:0] left_q;
	logic            out_valid_q;
	logic [ValW-1:0] sum_q;
	logic            status_q;

	logic            node_we;
	logic [AW-1:0]   node_waddr;
	logic [ValW-1:0] node_wdata;
	logic [AW-1:0]   node_raddr;
	logic [ValW-1:0] node_rdata;
	logic            pend_we;
	logic [PW-1:0]   pend_waddr;
	logic [ValW-1:0] pend_wdata;
	logic [PW-1:0]   pend_raddr;
	logic [ValW-1:0] pend_rdata;

	logic [NW-1:0]   pos_leaf;
	logic [NW-1:0]   push_i;
	logic [NW-1:0]   push_c;
	logic [NW-1:0]   reb_p;
	logic [NW-1:0]   r_dec;
	logic            accept;
	logic            bad_range;
	logic            acc_set;
	logic            deliver;

	lsta_ram #(.WIDTH(ValW), .DEPTH(2 * CAPACITY)) u_node_ram (
		.clk  (clk),
		.we   (node_we),
		.waddr(node_waddr),
		.wdata(node_wdata),
		.raddr(node_raddr),
		.rdata(node_rdata)
	);

	lsta_ram #(.WIDTH(ValW), .DEPTH(CAPACITY)) u_pend_ram (
		.clk  (clk),
		.we   (pend_we),
		.waddr(pend_waddr),
		.wdata(pend_wdata),
		.raddr(pend_raddr),
		.rdata(pend_rdata)
	);

	assign in_stall  = (st_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign bad_range = ({1'b0, lo} >= hi) || (hi > CapH);
	assign out_valid = out_valid_q;
	assign sum       = sum_q;
	assign status    = status_q;

	// A sum walk reads one node in each of these cycles; the data lands in the
	// next cycle.
	assign acc_set = (kind_q == KIND_SUM) &&
		(((st_q == S_LOOP_L) && (l_q < r_q) && l_q[0]) ||
		((st_q == S_LOOP_R) && r_q[0]));
	assign deliver = (st_q == S_DONE) && (!out_valid_q || !out_stall);

	// Path geometry for the leaf being pushed, and the node being rebuilt.
	assign pos_leaf = NW'(leaf_q) + CapN;
	assign push_i   = pos_leaf >> lvl_q;
	assign push_c   = push_i << 1;
	assign reb_p    = pos_q >> 1;
	assign r_dec    = r_q - 1'b1;

	always_comb begin
		node_we    = 1'b0;
		node_waddr = '0;
		node_wdata = '0;
		node_raddr = '0;
		pend_we    = 1'b0;
		pend_waddr = '0;
		pend_wdata = '0;
		pend_raddr = '0;
		unique case (st_q)
			S_CLR: begin
				node_we    = 1'b1;
				node_waddr = clr_q;
				pend_we    = ({1'b0, clr_q} < CapN);
				pend_waddr = PW'(clr_q);
			end
			S_PUSH_RD: begin
				pend_raddr = PW'(push_i);
			end
			S_PUSH_W1: begin
				// The pending value is split onto both children.
				node_we    = (pend_rdata != '0) && (push_i < CapN);
				node_waddr = AW'(push_c);
				node_wdata = pend_rdata << (lvl_q - 1'b1);
				pend_we    = node_we && (push_c < CapN);
				pend_waddr = PW'(push_c);
				pend_wdata = pend_rdata;
			end
			S_PUSH_W2: begin
				node_we    = 1'b1;
				node_waddr = AW'(push_c | 1'b1);
				node_wdata = d_q << (lvl_q - 1'b1);
				pend_we    = ((push_c | 1'b1) < CapN);
				pend_waddr = PW'(push_c | 1'b1);
				pend_wdata = d_q;
			end
			S_PUSH_W3: begin
				pend_we    = 1'b1;
				pend_waddr = PW'(push_i);
			end
			S_LOAD_W: begin
				node_we    = 1'b1;
				node_waddr = AW'(pos_leaf);
				node_wdata = v_q;
			end
			S_LOOP_L: begin
				if (l_q < r_q && l_q[0]) begin
					node_raddr = AW'(l_q);
					if (kind_q == KIND_ASSIGN) begin
						node_we    = 1'b1;
						node_waddr = AW'(l_q);
						node_wdata = v_q << lvl_q;
						pend_we    = (l_q < CapN);
						pend_waddr = PW'(l_q);
						pend_wdata = v_q;
					end
				end
			end
			S_LOOP_R: begin
				if (r_q[0]) begin
					node_raddr = AW'(r_dec);
					if (kind_q == KIND_ASSIGN) begin
						node_we    = 1'b1;
						node_waddr = AW'(r_dec);
						node_wdata = v_q << lvl_q;
						pend_we    = (r_dec < CapN);
						pend_waddr = PW'(r_dec);
						pend_wdata = v_q;
					end
				end
			end
			S_REB_R1: begin
				pend_raddr = PW'(reb_p);
				node_raddr = AW'(pos_q & ~NW'(1));
			end
			S_REB_R2: begin
				node_raddr = AW'(pos_q | NW'(1));
			end
			S_REB_W: begin
				node_we    = 1'b1;
				node_waddr = AW'(reb_p);
				node_wdata = (pend_q == '0) ? (left_q + node_rdata) : (pend_q << lvl_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			acc_q       <= 1'b0;
			kind_q      <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			v_q         <= '0;
			pass_q      <= 1'b0;
			leaf_q      <= '0;
			lvl_q       <= '0;
			d_q         <= '0;
			l_q         <= '0;
			r_q         <= '0;
			pos_q       <= '0;
			total_q     <= '0;
			err_q       <= 1'b0;
			pend_q      <= '0;
			left_q      <= '0;
			sum_q       <= '0;
			status_q    <= 1'b0;
		end else begin
			if (deliver) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			// A sum read issued last cycle lands now.
			acc_q <= acc_set;
			if (acc_q) begin
				total_q <= total_q + node_rdata;
			end
			unique case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ClrLast) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						kind_q  <= kind;
						lo_q    <= lo;
						hi_q    <= hi;
						v_q     <= value;
						leaf_q  <= lo;
						pass_q  <= 1'b0;
						lvl_q   <= KW'(HEIGHT);
						total_q <= '0;
						err_q   <= 1'b0;
						if (kind == KIND_LOAD) begin
							if ({1'b0, lo} < CapH) begin
								st_q <= S_PUSH_RD;
							end
						end else if (kind == KIND_ASSIGN || kind == KIND_SUM) begin
							if (bad_range) begin
								err_q <= 1'b1;
								st_q  <= S_DONE;
							end else if (kind == KIND_ASSIGN && value == '0) begin
								st_q <= S_DONE;
							end else begin
								st_q <= S_PUSH_RD;
							end
						end
					end
				end
				S_PUSH_RD: begin
					st_q <= S_PUSH_W1;
				end
				S_PUSH_W1: begin
					d_q <= pend_rdata;
					if (pend_rdata != '0 && push_i < CapN) begin
						st_q <= S_PUSH_W2;
					end else if (lvl_q == KW'(1)) begin
						// Path pushed: pick what follows.
						if (kind_q == KIND_LOAD) begin
							st_q <= S_LOAD_W;
						end else if (!pass_q) begin
							pass_q <= 1'b1;
							leaf_q <= PW'(hi_q - 1'b1);
							lvl_q  <= KW'(HEIGHT);
							st_q   <= S_PUSH_RD;
						end else begin
							l_q   <= NW'(lo_q) + CapN;
							r_q   <= NW'(hi_q) + CapN;
							lvl_q <= '0;
							st_q  <= S_LOOP_L;
						end
					end else begin
						lvl_q <= lvl_q - 1'b1;
						st_q  <= S_PUSH_RD;
					end
				end
				S_PUSH_W2: begin
					st_q <= S_PUSH_W3;
				end
				S_PUSH_W3: begin
					if (lvl_q == KW'(1)) begin
						if (kind_q == KIND_LOAD) begin
							st_q <= S_LOAD_W;
						end else if (!pass_q) begin
							pass_q <= 1'b1;
							leaf_q <= PW'(hi_q - 1'b1);
							lvl_q  <= KW'(HEIGHT);
							st_q   <= S_PUSH_RD;
						end else begin
							l_q   <= NW'(lo_q) + CapN;
							r_q   <= NW'(hi_q) + CapN;
							lvl_q <= '0;
							st_q  <= S_LOOP_L;
						end
					end else begin
						lvl_q <= lvl_q - 1'b1;
						st_q  <= S_PUSH_RD;
					end
				end
				S_LOAD_W: begin
					pass_q <= 1'b0;
					pos_q  <= pos_leaf;
					lvl_q  <= KW'(1);
					st_q   <= S_REB_R1;
				end
				S_LOOP_L: begin
					if (l_q < r_q) begin
						if (l_q[0]) begin
							l_q <= l_q + 1'b1;
						end
						st_q <= S_LOOP_R;
					end else if (kind_q == KIND_SUM) begin
						st_q <= S_DONE;
					end else begin
						leaf_q <= lo_q;
						pass_q <= 1'b0;
						pos_q  <= NW'(lo_q) + CapN;
						lvl_q  <= KW'(1);
						st_q   <= S_REB_R1;
					end
				end
				S_LOOP_R: begin
					if (r_q[0]) begin
						r_q <= r_dec >> 1;
					end else begin
						r_q <= r_q >> 1;
					end
					l_q   <= l_q >> 1;
					lvl_q <= lvl_q + 1'b1;
					st_q  <= S_LOOP_L;
				end
				S_REB_R1: begin
					if (pos_q > NW'(1)) begin
						st_q <= S_REB_R2;
					end else if (kind_q == KIND_ASSIGN && !pass_q) begin
						pass_q <= 1'b1;
						pos_q  <= NW'(hi_q - 1'b1) + CapN;
						lvl_q  <= KW'(1);
					end else if (kind_q == KIND_ASSIGN) begin
						st_q <= S_DONE;
					end else begin
						st_q <= S_IDLE;
					end
				end
				S_REB_R2: begin
					pend_q <= pend_rdata;
					left_q <= node_rdata;
					st_q   <= S_REB_W;
				end
				S_REB_W: begin
					pos_q <= reb_p;
					lvl_q <= lvl_q + 1'b1;
					st_q  <= S_REB_R1;
				end
				S_DONE: begin
					if (deliver) begin
						sum_q    <= total_q;
						status_q <= err_q;
						st_q     <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// No result may appear while the stores are still being cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_CLR) |=> !$rose(out_valid_q))
		else $error("result during clearing sweep");

	// A waiting result must not be overwritten while the receiver stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(sum_q) && $stable(status_q)))
		else $error("stalled result changed");

	// Error results always carry a zero sum.
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_DONE && err_q) |-> (total_q == '0))
		else $error("error result with nonzero sum");

	// Node writes stay inside the tree.
	assert property (@(posedge clk) disable iff (!arst_n)
		node_we |-> ({1'b0, node_waddr} < NW'(2 * CAPACITY)))
		else $error("node write out of range");
endmodule
